@@ hdl/bst_pkg.sv @@
// Package for the buffered serial transmitter.
// Holds word types, controller/datapath command and status structs and shared constants.
// No dependencies.
package bst_pkg;

    // default depth of the byte buffer
    localparam int BUFFER_DEPTH_DEF = 32;

    // first value of the walking data-bit mask
    localparam logic [7:0] MASK_FIRST = 8'h01;

    // input word: mode 0 enqueues data_byte, mode 1 is one bit-time tick
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_item;

    // result word, one per input word
    typedef struct packed {
        logic tx_line;
        logic accepted;
        logic dropped;
        logic busy_res;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input word
        logic exec;        // execute cycle: register the result word
        logic store;       // append the byte to the buffer
        logic drop;        // flag a dropped byte
        logic load_shift;  // start bit: load shifter from buffer, line low
        logic shift_bit;   // drive the next data bit
        logic stop;        // stop bit: line high, advance read index
        logic clear;       // with stop: last byte sent, reset both indices
        logic run_next;    // transmitter running after this word
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;        // buffer holds its full depth
        logic mask_zero;   // all eight data bits sent
        logic last;        // byte being sent is the last stored one
    } t_sts;

endpackage

@@ hdl/buffered_serial_transmitter.sv @@
// Buffered serial transmitter (8N1) with a linear byte buffer: top level.
// Instantiates bst_ctrl and bst_dp; depends on bst_pkg for word types.
//
// Each input word passes through the idle and execute states: busy is high
// in the cycle after start is taken, and no new word is taken while busy.
// The result word follows on o_result with o_valid high for one cycle,
// registered from the execute state; the receiver cannot stall it. The pace
// is set by the buffer's registered read port, which must settle on the
// read index before a start-bit tick loads the shifter. Enqueue words fill
// the buffer; tick words step the line through start, eight data bits
// (LSB first) and stop, and the buffer empties back to index zero when
// its last byte has been sent. No clearing pass follows reset.
module buffered_serial_transmitter #(
    parameter int BUFFER_DEPTH = bst_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bst_pkg::t_in_item  i_item,
    output logic               o_valid,
    output bst_pkg::t_out_item o_result
);

    bst_pkg::t_cmd w_cmd;
    bst_pkg::t_sts w_sts;

    bst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    bst_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_item.data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // execute lasts a single cycle
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // every taken word yields its result word
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result word missing");

    // a word is never both stored and dropped
    a_acc_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.accepted && o_result.dropped))
        else $error("word both stored and dropped");

    // a drop on a full buffer implies the transmitter is running
    a_drop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.dropped) |-> o_result.busy_res)
        else $error("drop while transmitter idle");

endmodule

@@ hdl/bst_ctrl.sv @@
// Controller of the buffered serial transmitter: word sequencing and frame phase.
// Depends on bst_pkg for the command and status structs.
module bst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_mode,
    input  bst_pkg::t_sts i_sts,
    output logic          o_busy,
    output bst_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_BITS  = 2'd2;

    logic       r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_running, n_running;
    logic       r_mode;
    logic       w_accept;

    assign o_busy   = (r_state == S_EXEC);
    assign w_accept = i_start && (r_state == S_IDLE);

    // decode the held word into datapath commands and next phase
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_running = r_running;
        o_cmd     = '0;
        o_cmd.load = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                o_cmd.exec = 1'b1;
                if (!r_mode) begin
                    if (i_sts.full) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.store = 1'b1;
                        if (!r_running) begin
                            n_phase   = PH_START;
                            n_running = 1'b1;
                        end
                    end
                end else begin
                    case (r_phase)
                        PH_START: begin
                            o_cmd.load_shift = 1'b1;
                            n_phase          = PH_BITS;
                        end
                        PH_BITS: begin
                            if (i_sts.mask_zero) begin
                                o_cmd.stop = 1'b1;
                                if (i_sts.last) begin
                                    o_cmd.clear = 1'b1;
                                    n_phase     = PH_IDLE;
                                    n_running   = 1'b0;
                                end else begin
                                    n_phase = PH_START;
                                end
                            end else begin
                                o_cmd.shift_bit = 1'b1;
                            end
                        end
                        default: begin
                            // idle or unused code: tick does nothing
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.run_next = n_running;
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_running <= n_running;
        end
    end

    // capture the mode of an accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
        end
    end

endmodule

@@ hdl/bst_dp.sv @@
// Datapath of the buffered serial transmitter: byte buffer, indices, shifter, line, result.
// Depends on bst_pkg for word types, command and status structs.
module bst_dp #(
    parameter int BUFFER_DEPTH = bst_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_data_byte,
    input  bst_pkg::t_cmd      i_cmd,
    output bst_pkg::t_sts      o_sts,
    output logic               o_valid,
    output bst_pkg::t_out_item o_result
);

    localparam int IW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0]         r_mem [BUFFER_DEPTH];
    logic [7:0]         r_rd_data;
    logic [7:0]         r_data;
    logic [IW-1:0]      r_wr_idx;
    logic [IW-1:0]      r_rd_idx;
    logic [IW-1:0]      w_rd_inc;
    logic [7:0]         r_shift;
    logic [7:0]         r_mask;
    logic               r_line, n_line;
    logic               r_valid;
    bst_pkg::t_out_item r_result;

    assign w_rd_inc        = r_rd_idx + IW'(1);
    assign o_sts.full      = (r_wr_idx == IW'(BUFFER_DEPTH));
    assign o_sts.mask_zero = (r_mask == 8'd0);
    assign o_sts.last      = (w_rd_inc >= r_wr_idx);

    // capture the byte of an accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data <= i_data_byte;
        end
    end

    // buffer: write on store, registered read at the read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_wr_idx[AW-1:0]] <= r_data;
        end
        r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
    end

    // advance the indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else if (i_cmd.store) begin
            r_wr_idx <= r_wr_idx + IW'(1);
        end else if (i_cmd.stop) begin
            if (i_cmd.clear) begin
                r_wr_idx <= '0;
                r_rd_idx <= '0;
            end else begin
                r_rd_idx <= w_rd_inc;
            end
        end
    end

    // next line level
    always_comb begin
        n_line = r_line;
        if (i_cmd.load_shift) begin
            n_line = 1'b0;
        end else if (i_cmd.shift_bit) begin
            n_line = r_shift[0];
        end else if (i_cmd.stop) begin
            n_line = 1'b1;
        end
    end

    // shifter, mask and line level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_mask  <= '0;
            r_line  <= 1'b1;
        end else begin
            r_line <= n_line;
            if (i_cmd.load_shift) begin
                r_shift <= r_rd_data;
                r_mask  <= bst_pkg::MASK_FIRST;
            end else if (i_cmd.shift_bit) begin
                r_shift <= {1'b0, r_shift[7:1]};
                r_mask  <= {r_mask[6:0], 1'b0};
            end
        end
    end

    // register the result word and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
        end
        if (i_cmd.exec) begin
            r_result.tx_line  <= n_line;
            r_result.accepted <= i_cmd.store;
            r_result.dropped  <= i_cmd.drop;
            r_result.busy_res <= i_cmd.run_next;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ tb/bst_tb_pkg.sv @@
`timescale 1ns / 100ps
// Shared codes for the buffered serial transmitter testbench.
// Holds the word mode codes used by the stimulus and the checker; depends on nothing.
package bst_tb_pkg;

    // mode field of an input word
    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

endpackage

@@ tb/bst_word_checker.sv @@
`timescale 1ns / 100ps
// Checker for the buffered serial transmitter: predicts each result word and compares.
// Depends on bst_pkg for word types and on bst_tb_pkg for mode codes.
module bst_word_checker #(
    parameter int DEPTH = bst_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  bst_pkg::t_in_item   i_item,
    input  logic                i_valid,
    input  bst_pkg::t_out_item  i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_frames,
    output int                  o_drops
);

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_BITS} t_frame_phase;

    // mirror of the transmitter state
    logic [7:0]   byte_buf [DEPTH];
    int           wr_idx;
    int           rd_idx;
    logic [7:0]   shifter;
    logic [7:0]   mask;
    t_frame_phase phase;
    logic         running;
    logic         line;

    bst_pkg::t_out_item line_expect_q [$];
    int                 n_results;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_frames     = 0;
        o_drops      = 0;
        n_results    = 0;
    end

    task automatic report_mismatch(input string field, input logic got, input logic want);
        $display("mismatch in result word %0d: %s got %b, expected %b",
                 n_results, field, got, want);
        o_fail_count++;
    endtask

    // apply one input word to the mirror and return the result word it causes
    function automatic bst_pkg::t_out_item advance_line_state(input bst_pkg::t_in_item w);
        bst_pkg::t_out_item r;
        r = '0;
        if (w.mode == bst_tb_pkg::MODE_ENQUEUE) begin
            if (wr_idx >= DEPTH) begin
                r.dropped = 1'b1;
                o_drops++;
            end else begin
                byte_buf[wr_idx] = w.data_byte;
                wr_idx++;
                r.accepted = 1'b1;
                if (!running) begin
                    phase   = PH_START;
                    running = 1'b1;
                end
            end
        end else begin
            case (phase)
                PH_START: begin
                    phase   = PH_BITS;
                    mask    = bst_pkg::MASK_FIRST;
                    shifter = byte_buf[rd_idx];
                    line    = 1'b0;
                end
                PH_BITS: begin
                    if (mask == 8'h00) begin
                        // stop bit, then the next byte or back to idle
                        line = 1'b1;
                        rd_idx++;
                        o_frames++;
                        if (rd_idx >= wr_idx) begin
                            phase   = PH_IDLE;
                            running = 1'b0;
                            rd_idx  = 0;
                            wr_idx  = 0;
                        end else begin
                            shifter = byte_buf[rd_idx];
                            phase   = PH_START;
                        end
                    end else begin
                        line    = shifter[0];
                        shifter = shifter >> 1;
                        mask    = mask << 1;
                    end
                end
                default: ;
            endcase
        end
        r.tx_line  = line;
        r.busy_res = running;
        return r;
    endfunction

    // compare results first, then queue the prediction for a newly taken word
    always @(posedge i_clk) begin
        bst_pkg::t_out_item want;
        if (!i_rst_n) begin
            wr_idx  = 0;
            rd_idx  = 0;
            shifter = '0;
            mask    = '0;
            phase   = PH_IDLE;
            running = 1'b0;
            line    = 1'b1;
            line_expect_q.delete();
        end else begin
            if (i_valid) begin
                if (line_expect_q.size() == 0) begin
                    $display("result word %0d arrived with no word outstanding", n_results);
                    o_fail_count++;
                end else begin
                    want = line_expect_q.pop_front();
                    if (i_result.tx_line !== want.tx_line)
                        report_mismatch("tx_line", i_result.tx_line, want.tx_line);
                    if (i_result.accepted !== want.accepted)
                        report_mismatch("accepted", i_result.accepted, want.accepted);
                    if (i_result.dropped !== want.dropped)
                        report_mismatch("dropped", i_result.dropped, want.dropped);
                    if (i_result.busy_res !== want.busy_res)
                        report_mismatch("busy_res", i_result.busy_res, want.busy_res);
                end
                n_results++;
            end
            if (i_start && !i_busy)
                line_expect_q.push_back(advance_line_state(i_item));
        end
        o_pending = line_expect_q.size();
    end

endmodule

@@ tb/tb_buffered_serial_transmitter.sv @@
`timescale 1ns / 100ps
// Testbench top for the buffered serial transmitter: clock, reset, stimulus and verdict.
// Depends on bst_pkg, bst_tb_pkg, bst_word_checker and the transmitter RTL.
module tb_buffered_serial_transmitter;

    localparam int DEPTH       = bst_pkg::BUFFER_DEPTH_DEF;
    localparam int N_RANDOM    = 1330;
    localparam int STALL_LIMIT = 2000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    bst_pkg::t_in_item  item    = '0;
    logic               o_valid;
    bst_pkg::t_out_item o_result;

    int fail_count;
    int pending;
    int frames;
    int drops;
    int n_sent   = 0;
    int n_enq    = 0;
    int n_tick   = 0;
    int stall_cycles = 0;

    buffered_serial_transmitter #(.BUFFER_DEPTH(DEPTH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    bst_word_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frames     (frames),
        .o_drops      (drops)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // end the run when neither side moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one word, idle first at random but not for words 500-799, hold until taken
    task automatic send_word(input logic m, input logic [7:0] b);
        bst_pkg::t_in_item w;
        bit taken;
        w.mode      = m;
        w.data_byte = b;
        if ((n_sent < 500 || n_sent >= 800) && $urandom_range(99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(2, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        item  <= w;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        n_sent++;
        if (m == bst_tb_pkg::MODE_ENQUEUE)
            n_enq++;
        else
            n_tick++;
    endtask

    // drop start and hold until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int limit;
        int burst;
        int ticks;
        int k;
        bit paused;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ticks, byte extremes, an enqueue while running, two full frames
        send_word(bst_tb_pkg::MODE_TICK, 8'hFF);
        send_word(bst_tb_pkg::MODE_TICK, 8'h00);
        send_word(bst_tb_pkg::MODE_ENQUEUE, 8'h00);
        send_word(bst_tb_pkg::MODE_TICK, 8'hFF);
        send_word(bst_tb_pkg::MODE_ENQUEUE, 8'hFF);
        for (k = 0; k < 19; k++)
            send_word(bst_tb_pkg::MODE_TICK, 8'($urandom));
        send_word(bst_tb_pkg::MODE_TICK, 8'h00);

        // bursts of bytes followed by ticks; long bursts can run past the buffer depth
        limit  = n_sent + N_RANDOM;
        paused = 0;
        while (n_sent < limit) begin
            if (n_sent < 30 || $urandom_range(7) == 0)
                burst = $urandom_range(DEPTH - 2, DEPTH + 4);
            else
                burst = $urandom_range(1, 3);
            for (k = 0; k < burst && n_sent < limit; k++)
                send_word(bst_tb_pkg::MODE_ENQUEUE, 8'($urandom));
            ticks = $urandom_range(4, 10 * burst + 12);
            for (k = 0; k < ticks && n_sent < limit; k++) begin
                if ($urandom_range(19) == 0)
                    send_word(bst_tb_pkg::MODE_ENQUEUE, 8'($urandom));
                else
                    send_word(bst_tb_pkg::MODE_TICK, 8'($urandom));
            end
            if (!paused && n_sent > limit - N_RANDOM / 2) begin
                drain_results();
                paused = 1;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("sent %0d words (%0d enqueues, %0d ticks)", n_sent, n_enq, n_tick);
        $display("completed %0d frames, dropped %0d bytes on a full buffer", frames, drops);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ buffered_serial_transmitter.f @@
hdl/bst_pkg.sv
hdl/bst_ctrl.sv
hdl/bst_dp.sv
hdl/buffered_serial_transmitter.sv
tb/bst_tb_pkg.sv
tb/bst_word_checker.sv
tb/tb_buffered_serial_transmitter.sv
